[rtl/core/q2e_pkg.sv]
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared types, constants and tables for the quaternion to Euler angle block.
// ----------------------------------------------------------------------------
`default_nettype none
package q2e_pkg;
	localparam int CORDIC_STAGES = 16;
	localparam int QW = 32;
	localparam int AW = 16;
	localparam int VW = 40;   // cordic vector width, values stay below 2^37
	localparam int ZW = 28;   // angle accumulator width, Q.24
	localparam int SQ_STEPS = 31; // one result bit per cell of the root chain
	localparam int SW = 62;   // root remainder width

	localparam logic signed [ZW-1:0] ANG_PI = ZW'(52707179);
	localparam logic signed [VW-1:0] ONE_Q30 = VW'(64'sd1073741824);

	typedef logic signed [QW-1:0] quat_t;
	typedef logic signed [AW-1:0] angle_t;
	typedef logic signed [VW-1:0] vec_t;
	typedef logic signed [ZW-1:0] ang_acc_t;

	// one vector being rotated toward the x axis
	typedef struct packed {
		vec_t     x;
		vec_t     y;
		ang_acc_t z;
	} cvec_t;

	function automatic ang_acc_t atan_entry(input int i);
		case (i)
			0: atan_entry = ZW'(13176795);
			1: atan_entry = ZW'(7778716);
			2: atan_entry = ZW'(4110060);
			3: atan_entry = ZW'(2086331);
			4: atan_entry = ZW'(1047214);
			5: atan_entry = ZW'(524117);
			6: atan_entry = ZW'(262123);
			7: atan_entry = ZW'(131069);
			default: atan_entry = (i < 25) ? ZW'(65536 >> (i - 8)) : '0;
		endcase
	endfunction
endpackage
`default_nettype wire

[rtl/core/q2e_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// q2e_sqrt_cell
// One bit step of the restoring square root chain, registered.
// ----------------------------------------------------------------------------
`default_nettype none
module q2e_sqrt_cell (
	input  wire logic                      clk,
	input  wire logic [5:0]                bitpos,
	input  wire logic [q2e_pkg::SW-1:0]    rem_in,
	input  wire logic [30:0]               root_in,
	output logic      [q2e_pkg::SW-1:0]    rem_s1,
	output logic      [30:0]               root_s1
);
	import q2e_pkg::*;
	logic [SW+1:0] trial;
	logic [SW+1:0] rem_w;
	always_comb begin
		// try root bit at bitpos: (2*root + 2^b) * 2^b
		trial = ((SW+2)'(root_in) << (bitpos + 6'd1)) + ((SW+2)'(1) << (bitpos << 1));
		rem_w = (SW+2)'(rem_in);
	end
	always_ff @(posedge clk) begin
		if (rem_w >= trial) begin
			rem_s1  <= SW'(rem_w - trial);
			root_s1 <= root_in | (31'(1) << bitpos);
		end else begin
			rem_s1  <= rem_in;
			root_s1 <= root_in;
		end
	end
endmodule
`default_nettype wire

[rtl/core/q2e_cordic_cell.sv]
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// One registered vectoring micro-rotation, three lanes side by side.
// ----------------------------------------------------------------------------
`default_nettype none
module q2e_cordic_cell (
	input  wire logic             clk,
	input  wire logic [4:0]       shift,
	input  q2e_pkg::ang_acc_t     step_ang,
	input  q2e_pkg::cvec_t [2:0]  v_in,
	output q2e_pkg::cvec_t [2:0]  v_s1
);
	import q2e_pkg::*;
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (!v_in[k].y[VW-1]) begin
				v_s1[k].x <= v_in[k].x + (v_in[k].y >>> shift);
				v_s1[k].y <= v_in[k].y - (v_in[k].x >>> shift);
				v_s1[k].z <= v_in[k].z + step_ang;
			end else begin
				v_s1[k].x <= v_in[k].x - (v_in[k].y >>> shift);
				v_s1[k].y <= v_in[k].y + (v_in[k].x >>> shift);
				v_s1[k].z <= v_in[k].z - step_ang;
			end
		end
	end
endmodule
`default_nettype wire

[rtl/core/quaternion_to_euler_angles.sv]
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Quaternion (Q1.30) to roll, pitch, yaw (Q2.13 radians), Z-Y-X convention.
// ----------------------------------------------------------------------------
// Usage: drive quat_w..quat_z and pulse start; a transaction is taken at a
// rising edge with start high and busy low. busy is tied low: the block is a
// fully pipelined row of cells and takes one quaternion every cycle.
// The pipeline runs through products, sums and clamp, 31 square root bit
// cells, pre-rotation, CORDIC_STAGES rotation cells, then rounding. Each
// result appears on roll_angle, pitch_angle and yaw_angle for exactly one
// cycle with done high. The receiver cannot stall; results are never held.
// Reset clears only the valid chain; data registers are not reset, so no
// done is raised for items not taken after reset.
// ----------------------------------------------------------------------------
`default_nettype none
module quaternion_to_euler_angles (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  q2e_pkg::quat_t       quat_w,
	input  q2e_pkg::quat_t       quat_x,
	input  q2e_pkg::quat_t       quat_y,
	input  q2e_pkg::quat_t       quat_z,
	output logic                 done,
	output q2e_pkg::angle_t      roll_angle,
	output q2e_pkg::angle_t      pitch_angle,
	output q2e_pkg::angle_t      yaw_angle
);
	import q2e_pkg::*;
	localparam int LAT = 2 + SQ_STEPS + 1 + CORDIC_STAGES + 1;

	assign busy = 1'b0;

	logic [LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end
	assign done = vld_q[LAT-1];

	// stage 1: nine products, each taken as floor(p/2^29)
	logic signed [63:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_xz, p_xy, p_wz, p_zz;
	logic signed [34:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, xz_s1, xy_s1, wz_s1, zz_s1;
	always_comb begin
		p_wx = quat_w * quat_x; p_yz = quat_y * quat_z;
		p_xx = quat_x * quat_x; p_yy = quat_y * quat_y;
		p_wy = quat_w * quat_y; p_xz = quat_x * quat_z;
		p_xy = quat_x * quat_y; p_wz = quat_w * quat_z;
		p_zz = quat_z * quat_z;
	end
	always_ff @(posedge clk) begin
		wx_s1 <= 35'(p_wx >>> 29); yz_s1 <= 35'(p_yz >>> 29);
		xx_s1 <= 35'(p_xx >>> 29); yy_s1 <= 35'(p_yy >>> 29);
		wy_s1 <= 35'(p_wy >>> 29); xz_s1 <= 35'(p_xz >>> 29);
		xy_s1 <= 35'(p_xy >>> 29); wz_s1 <= 35'(p_wz >>> 29);
		zz_s1 <= 35'(p_zz >>> 29);
	end

	// stage 2: sums, clamp, root operand
	vec_t ry_s2, rx_s2, yy_s2, yx_s2, s_s2;
	logic [SW-1:0] rad_s2;
	vec_t s_raw;
	logic [30:0] mag;
	always_comb begin
		s_raw = VW'(wy_s1) - VW'(xz_s1);
		if (s_raw > ONE_Q30) s_raw = ONE_Q30;
		if (s_raw < -ONE_Q30) s_raw = -ONE_Q30;
		mag = s_raw[VW-1] ? 31'(-s_raw) : 31'(s_raw);
	end
	always_ff @(posedge clk) begin
		ry_s2 <= VW'(wx_s1) + VW'(yz_s1);
		rx_s2 <= ONE_Q30 - VW'(xx_s1) - VW'(yy_s1);
		yy_s2 <= VW'(xy_s1) + VW'(wz_s1);
		yx_s2 <= ONE_Q30 - VW'(yy_s1) - VW'(zz_s1);
		s_s2  <= s_raw;
		rad_s2 <= (SW'(1) << 60) - SW'(62'(mag) * 62'(mag));
	end

	// square root chain, with roll/pitch/yaw operands carried alongside
	logic [SW-1:0] rem_c [SQ_STEPS+1];
	logic [30:0]   root_c [SQ_STEPS+1];
	vec_t          d_c [SQ_STEPS+1][5];
	assign rem_c[0]  = rad_s2;
	assign root_c[0] = '0;
	assign d_c[0][0] = ry_s2;
	assign d_c[0][1] = rx_s2;
	assign d_c[0][2] = s_s2;
	assign d_c[0][3] = yy_s2;
	assign d_c[0][4] = yx_s2;
	for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
		q2e_sqrt_cell u_cell (
			.clk     (clk),
			.bitpos  (6'(SQ_STEPS - 1 - g)),
			.rem_in  (rem_c[g]),
			.root_in (root_c[g]),
			.rem_s1  (rem_c[g+1]),
			.root_s1 (root_c[g+1])
		);
		always_ff @(posedge clk) begin
			d_c[g+1] <= d_c[g];
		end
	end

	// pre-rotation into the right half plane
	cvec_t [2:0] pre;
	cvec_t [2:0] pre_s1;
	always_comb begin
		pre[0] = '{x: d_c[SQ_STEPS][1], y: d_c[SQ_STEPS][0], z: '0};
		pre[1] = '{x: VW'(root_c[SQ_STEPS]), y: d_c[SQ_STEPS][2], z: '0};
		pre[2] = '{x: d_c[SQ_STEPS][4], y: d_c[SQ_STEPS][3], z: '0};
		for (int k = 0; k < 3; k++) begin
			if (pre[k].x[VW-1]) begin
				pre[k].z = pre[k].y[VW-1] ? -ANG_PI : ANG_PI;
				pre[k].x = -pre[k].x;
				pre[k].y = -pre[k].y;
			end
		end
	end
	logic [2:0] zero_c [CORDIC_STAGES+1];
	always_ff @(posedge clk) begin
		pre_s1 <= pre;
		for (int k = 0; k < 3; k++)
			zero_c[0][k] <= (pre[k].x == '0) && (pre[k].y == '0);
	end

	cvec_t [2:0] v_c [CORDIC_STAGES+1];
	assign v_c[0] = pre_s1;
	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cr
		q2e_cordic_cell u_cell (
			.clk      (clk),
			.shift    (5'(g)),
			.step_ang (atan_entry(g)),
			.v_in     (v_c[g]),
			.v_s1     (v_c[g+1])
		);
		always_ff @(posedge clk) begin
			zero_c[g+1] <= zero_c[g];
		end
	end

	// rounding to Q2.13 with saturation
	function automatic angle_t to_q13(input ang_acc_t z, input logic zero);
		ang_acc_t r;
		begin
			r = (z + ZW'(1024)) >>> 11;
			if (zero) to_q13 = '0;
			else if (r > ZW'(32767)) to_q13 = 16'sh7fff;
			else if (r < -ZW'(32768)) to_q13 = 16'sh8000;
			else to_q13 = AW'(r);
		end
	endfunction
	always_ff @(posedge clk) begin
		roll_angle  <= to_q13(v_c[CORDIC_STAGES][0].z, zero_c[CORDIC_STAGES][0]);
		pitch_angle <= to_q13(v_c[CORDIC_STAGES][1].z, zero_c[CORDIC_STAGES][1]);
		yaw_angle   <= to_q13(v_c[CORDIC_STAGES][2].z, zero_c[CORDIC_STAGES][2]);
	end
endmodule
`default_nettype wire

[rtl/core/q2e_checker.sv]
// ----------------------------------------------------------------------------
// q2e_checker
// Port-level checks for the quaternion to Euler angle block.
// ----------------------------------------------------------------------------
`default_nettype none
module q2e_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            start,
	input wire logic            busy,
	input wire logic            done,
	input q2e_pkg::angle_t      pitch_angle
);
	import q2e_pkg::*;
	localparam int LAT = 2 + SQ_STEPS + 1 + CORDIC_STAGES + 1;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("missing result");
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pitch_angle <= 16'sd12900) && (pitch_angle >= -16'sd12900))
		else $error("pitch beyond pi/2");
endmodule

bind quaternion_to_euler_angles q2e_checker u_q2e_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.pitch_angle (pitch_angle)
);
`default_nettype wire
